### src/rvs_pkg.sv
package rvs_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int TOL_W = 20;
    localparam int COORD_W = 32;
    localparam int TAG_W = 6;
    localparam logic [TOL_W-1:0] TOL_RESET = 20'd1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_P1_PRIME,
        ST_P1_RUN,
        ST_P1_LAST,
        ST_P2_PRIME0,
        ST_P2_PRIME1,
        ST_P2_RUN,
        ST_P2_TAIL,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMPTY
    } rvs_state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [TAG_W-1:0]          tag;
    } rvs_vertex_t;

    function automatic logic near_eq(input logic signed [COORD_W-1:0] a,
                                     input logic signed [COORD_W-1:0] b,
                                     input logic [TOL_W-1:0] tol);
        logic signed [COORD_W:0] d;
        logic [COORD_W:0] m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m <= {{(COORD_W+1-TOL_W){1'b0}}, tol};
    endfunction

endpackage

### src/ring_vertex_simplifier.sv
// Ring vertex simplifier. Vertices load one per cycle into a vertex memory of MAX_POINTS
// entries; the item with last_point high closes the ring. Vertices beyond capacity are
// dropped and flagged on every result of that ring. Pass one removes vertices equal
// (within tolerance) to their cyclic successor, pass two removes the middle vertex of
// cyclic triples on one horizontal or vertical line (within tolerance) when three or more
// remain; each pass streams through the memory one entry per cycle, writing survivors back
// in place through a compaction pointer. The ring then streams out with one memory read
// per result, each read issued only once the output register is empty or being taken.
// Input is not taken during processing. An empty result ring yields one marker item.
module ring_vertex_simplifier #(
    parameter int MAX_POINTS = rvs_pkg::DEF_MAX_POINTS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [rvs_pkg::TOL_W-1:0]        cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [31:0]               s_point_x,
    input  logic signed [31:0]               s_point_y,
    input  logic [3:0]                       s_plate_tag,
    input  logic [1:0]                       s_corner_tag,
    input  logic                             s_last_point,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [31:0]               m_out_x,
    output logic signed [31:0]               m_out_y,
    output logic [3:0]                       m_out_plate,
    output logic [1:0]                       m_out_corner,
    output logic                             m_point_valid,
    output logic                             m_overflowed,
    output logic                             m_end_of_ring
);
    import rvs_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] CAP = CW'(MAX_POINTS);

    rvs_vertex_t mem [MAX_POINTS];
    rvs_vertex_t rd_data;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    rvs_vertex_t   wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

    rvs_state_t state_reg, state_next;
    logic [TOL_W-1:0] tol_reg;
    logic [CW-1:0] cnt_reg, cnt_next;      // stored vertices
    logic [CW-1:0] idx_reg, idx_next;      // read index
    logic [CW-1:0] wp_reg, wp_next;        // compaction write pointer
    logic          ovf_reg, ovf_next;
    rvs_vertex_t   first_reg, first_next;  // entry 0
    rvs_vertex_t   a_reg, a_next, b_reg, b_next;
    logic          out_valid_reg, out_valid_next;
    rvs_vertex_t   out_v_reg, out_v_next;
    logic          out_pv_reg, out_pv_next, out_eor_reg, out_eor_next;

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = out_valid_reg;
    assign m_out_x = out_v_reg.x;
    assign m_out_y = out_v_reg.y;
    assign m_out_plate = out_v_reg.tag[5:2];
    assign m_out_corner = out_v_reg.tag[1:0];
    assign m_point_valid = out_pv_reg;
    assign m_overflowed = ovf_reg;
    assign m_end_of_ring = out_eor_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            tol_reg <= TOL_RESET;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                tol_reg <= cfg_wdata;
            end
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
        idx_reg <= idx_next;
        wp_reg <= wp_next;
        first_reg <= first_next;
        a_reg <= a_next;
        b_reg <= b_next;
        out_v_reg <= out_v_next;
        out_pv_reg <= out_pv_next;
        out_eor_reg <= out_eor_next;
    end

    function automatic logic dup(input rvs_vertex_t p, input rvs_vertex_t q,
                                 input logic [TOL_W-1:0] t);
        return near_eq(p.x, q.x, t) && near_eq(p.y, q.y, t);
    endfunction

    function automatic logic coll(input rvs_vertex_t p, input rvs_vertex_t q,
                                  input rvs_vertex_t r, input logic [TOL_W-1:0] t);
        return (near_eq(p.x, q.x, t) && near_eq(q.x, r.x, t)) ||
               (near_eq(p.y, q.y, t) && near_eq(q.y, r.y, t));
    endfunction

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        wp_next = wp_reg;
        ovf_next = ovf_reg;
        first_next = first_reg;
        a_next = a_reg;
        b_next = b_reg;
        out_valid_next = out_valid_reg;
        out_v_next = out_v_reg;
        out_pv_next = out_pv_reg;
        out_eor_next = out_eor_reg;
        rd_en = 1'b0;
        rd_addr = idx_reg[AW-1:0];
        wr_en = 1'b0;
        wr_addr = wp_reg[AW-1:0];
        wr_data = a_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    if (cnt_reg < CAP) begin
                        wr_en = 1'b1;
                        wr_addr = cnt_reg[AW-1:0];
                        wr_data = '{x: s_point_x, y: s_point_y,
                                    tag: {s_plate_tag, s_corner_tag}};
                        if (cnt_reg == '0) begin
                            first_next = wr_data;
                        end
                        cnt_next = cnt_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_last_point) begin
                        idx_next = CW'(1);
                        wp_next = '0;
                        a_next = (cnt_reg == '0) ? wr_data : first_reg;
                        state_next = ST_P1_PRIME;
                    end
                end
            end
            // pass one: a_reg holds entry i, rd_data arrives with entry i+1
            ST_P1_PRIME: begin
                if (cnt_reg == CW'(1)) begin
                    state_next = ST_P1_LAST;
                end else begin
                    rd_en = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_P1_RUN;
                end
            end
            ST_P1_RUN: begin
                if (!dup(a_reg, rd_data, tol_reg)) begin
                    wr_en = 1'b1;
                    wp_next = wp_reg + 1'b1;
                end
                a_next = rd_data;
                if (idx_reg == cnt_reg) begin
                    state_next = ST_P1_LAST;
                end else begin
                    rd_en = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_P1_LAST: begin
                // successor of the final vertex is entry 0, still intact in first_reg
                if (!dup(a_reg, first_reg, tol_reg)) begin
                    wr_en = 1'b1;
                    wp_next = wp_reg + 1'b1;
                    cnt_next = wp_reg + 1'b1;
                end else begin
                    cnt_next = wp_reg;
                end
                state_next = ST_P2_PRIME0;
            end
            ST_P2_PRIME0: begin
                idx_next = '0;
                if (cnt_reg == '0) begin
                    state_next = ST_EMPTY;
                end else if (cnt_reg < CW'(3)) begin
                    state_next = ST_EMIT_RD;
                end else begin
                    // predecessor of vertex 0 is the final vertex
                    rd_en = 1'b1;
                    rd_addr = AW'(cnt_reg - 1'b1);
                    state_next = ST_P2_PRIME1;
                end
            end
            ST_P2_PRIME1: begin
                a_next = rd_data;
                rd_en = 1'b1;
                idx_next = CW'(1);
                wp_next = '0;
                state_next = ST_P2_RUN;
            end
            // b_reg is the middle vertex, a_reg its original predecessor
            ST_P2_RUN: begin
                if (idx_reg == CW'(1)) begin
                    first_next = rd_data;
                    b_next = rd_data;
                end else begin
                    if (!coll(a_reg, b_reg, rd_data, tol_reg)) begin
                        wr_en = 1'b1;
                        wr_data = b_reg;
                        wp_next = wp_reg + 1'b1;
                    end
                    a_next = b_reg;
                    b_next = rd_data;
                end
                if (idx_reg == cnt_reg) begin
                    state_next = ST_P2_TAIL;
                end else begin
                    rd_en = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_P2_TAIL: begin
                // middle = last vertex, successor = vertex 0
                idx_next = '0;
                if (!coll(a_reg, b_reg, first_reg, tol_reg)) begin
                    wr_en = 1'b1;
                    wr_data = b_reg;
                    cnt_next = wp_reg + 1'b1;
                    state_next = ST_EMIT_RD;
                end else begin
                    cnt_next = wp_reg;
                    state_next = (wp_reg == '0) ? ST_EMPTY : ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                if (!out_valid_reg || m_ready) begin
                    rd_en = 1'b1;
                    state_next = ST_EMIT_WAIT;
                end
            end
            ST_EMIT_WAIT: begin
                out_valid_next = 1'b1;
                out_v_next = rd_data;
                out_pv_next = 1'b1;
                out_eor_next = (idx_reg + 1'b1 == cnt_reg);
                if (idx_reg + 1'b1 == cnt_reg) begin
                    state_next = ST_EMPTY;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMPTY: begin
                if (!out_valid_reg || m_ready) begin
                    if (cnt_reg == '0) begin
                        out_valid_next = 1'b1;
                        out_v_next = '0;
                        out_pv_next = 1'b0;
                        out_eor_next = 1'b1;
                        cnt_next = CW'(1);
                    end else begin
                        // ring finished once the final item has been taken
                        if (!out_valid_reg || m_ready) begin
                            cnt_next = '0;
                            ovf_next = 1'b0;
                            state_next = ST_LOAD;
                        end
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end
endmodule
